// ----- rtl/brb_pkg.sv -----
// Shared types and constants for the Brian's Brain generation step block.
`default_nettype none

package brb_pkg;

    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int SIZE_W = 7;

    localparam logic [SIZE_W-1:0] MIN_SIZE = SIZE_W'(3);
    localparam logic [SIZE_W-1:0] MAX_W_SZ = SIZE_W'(MAX_WIDTH);
    localparam logic [SIZE_W-1:0] MAX_H_SZ = SIZE_W'(MAX_HEIGHT);

    // cell states
    localparam logic [1:0] CELL_OFF    = 2'd0;
    localparam logic [1:0] CELL_FIRING = 2'd1;
    localparam logic [1:0] CELL_DYING  = 2'd2;
    localparam logic [1:0] CELL_BAD    = 2'd3;

    // operation modes
    localparam logic [1:0] MODE_WRITE   = 2'd0;
    localparam logic [1:0] MODE_READ    = 2'd1;
    localparam logic [1:0] MODE_ADVANCE = 2'd2;
    localparam logic [1:0] MODE_NOP     = 2'd3;

    // configuration register indexes
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    typedef logic [MAX_WIDTH-1:0][1:0] row_t;

    // firing bits of one column of the three-row window
    typedef struct packed {
        logic up;
        logic cur;
        logic dn;
    } fire_t;

endpackage

`default_nettype wire

// ----- rtl/brb_if.sv -----
// Handshake channel interfaces: items, results and configuration writes.
`default_nettype none

interface brb_item_if import brb_pkg::*;;
    logic             valid;
    logic             ready;
    logic [1:0]       mode;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] column;
    logic [1:0]       write_value;

    modport source (output valid, mode, row, column, write_value, input ready);
    modport sink   (input valid, mode, row, column, write_value, output ready);
endinterface

interface brb_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] read_value;

    modport source (output valid, read_value, input ready);
    modport sink   (input valid, read_value, output ready);
endinterface

interface brb_cfg_if import brb_pkg::*;;
    logic              valid;
    logic              ready;
    logic              index;
    logic [SIZE_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/brb_cell.sv -----
// One column cell of the generation window: holds three rows, computes next state.
`default_nettype none

module brb_cell import brb_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       shift_en,
    input  wire logic [1:0] load_state,
    input  wire fire_t      left,
    input  wire fire_t      right,
    output fire_t           fire,
    output logic [1:0]      cur_state,
    output logic [1:0]      next_state
);

    logic       up_fire_reg;
    logic [1:0] cur_reg;
    logic [1:0] dn_reg;
    logic [3:0] count;

    // window moves down one row per shift
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            up_fire_reg <= (cur_reg == CELL_FIRING);
            cur_reg     <= dn_reg;
            dn_reg      <= load_state;
        end
    end

    assign fire.up   = up_fire_reg;
    assign fire.cur  = (cur_reg == CELL_FIRING);
    assign fire.dn   = (dn_reg == CELL_FIRING);
    assign cur_state = cur_reg;

    assign count = {3'b0, left.up} + {3'b0, left.cur} + {3'b0, left.dn}
                 + {3'b0, fire.up} + {3'b0, fire.dn}
                 + {3'b0, right.up} + {3'b0, right.cur} + {3'b0, right.dn};

    always_comb
    begin
        case (cur_reg)
            CELL_FIRING: next_state = CELL_DYING;
            CELL_DYING:  next_state = CELL_OFF;
            default:     next_state = (count == 4'd2) ? CELL_FIRING : CELL_OFF;
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/brb_grid_mem.sv -----
// Row-wide grid memory with per-row valid bits; an unwritten row reads as all off.
`default_nettype none

module brb_grid_mem import brb_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             we,
    input  wire logic [ROW_W-1:0] waddr,
    input  wire row_t             wdata,
    input  wire logic [ROW_W-1:0] raddr,
    output row_t                  rdata
);

    row_t                  row_mem [MAX_HEIGHT];
    row_t                  rdata_reg;
    logic [MAX_HEIGHT-1:0] valid_reg;
    logic                  rvalid_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            row_mem[waddr] <= wdata;
        end
        rdata_reg <= row_mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            rvalid_reg <= valid_reg[raddr];
        end
    end

    assign rdata = rvalid_reg ? rdata_reg : '0;

endmodule

`default_nettype wire

// ----- rtl/brians_brain_generation_step.sv -----
// Top level of the Brian's Brain generation step block.
// Holds a wrapped grid of up to 64 x 64 three-state cells (off, firing, dying), all off after
// reset. Each item is a cell write, a cell read, or one generation advance, and each gives
// exactly one result: the addressed cell after the operation, or 0 for advance, no-op and
// addresses outside the active board. Writes of the value 3 leave the cell unchanged.
// A cell write or read goes through a row read, a modify/write-back and the result
// register. Let h be the active height: the grid lives in a row-wide memory
// with one read and one write port, and rows stream one per cycle through a chain of 64
// column cells holding a three-row window; each cell takes its neighbors' firing bits and
// produces its column's next state. Row h-1 is read first to supply the wrap above row 0,
// and a copy of old row 0 supplies the wrap below row h-1. The result register parts the
// item and result sides: a new item may be taken while a result still waits for transfer.
// board_width and board_height are clamped to 3..64; write them only while idle.
`default_nettype none

module brians_brain_generation_step import brb_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    brb_item_if.sink     items,
    brb_result_if.source results,
    brb_cfg_if.sink      cfg
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACC,
        ST_ADV,
        ST_FIN
    } state_t;

    state_t state_reg;

    // configuration
    logic [SIZE_W-1:0] board_width_reg;
    logic [SIZE_W-1:0] board_height_reg;
    logic [SIZE_W-1:0] w_act;
    logic [SIZE_W-1:0] h_act;
    logic [SIZE_W-1:0] w_m1_full;
    logic [SIZE_W-1:0] h_m1_full;
    logic [COL_W-1:0]  w_m1;
    logic [ROW_W-1:0]  h_m1;

    // captured item
    logic [1:0]       op_mode_reg;
    logic [ROW_W-1:0] op_row_reg;
    logic [COL_W-1:0] op_col_reg;
    logic [1:0]       op_wv_reg;

    // advance sequencing
    logic [SIZE_W-1:0] rd_cnt_reg;
    logic              arr_valid_reg;
    logic [SIZE_W-1:0] arr_cnt_reg;
    logic              fin_reg;
    logic              wr_pend_reg;
    logic              wr_last_reg;
    logic [ROW_W-1:0]  wr_row_reg;
    logic [SIZE_W-1:0] arr_cnt_m2;
    row_t              row0_reg;

    // result
    logic [1:0] res_reg;
    logic       out_valid_reg;
    logic [1:0] out_value_reg;
    logic       out_load;

    // memory ports
    logic             mem_we;
    logic [ROW_W-1:0] mem_waddr;
    row_t             mem_wdata;
    logic [ROW_W-1:0] mem_raddr;
    row_t             rd_row;
    logic             adv_issue;
    logic [SIZE_W-1:0] rd_cnt_m1;

    // cell chain
    logic              shift_en;
    row_t              shift_data;
    fire_t             fire [MAX_WIDTH];
    fire_t             left_in [MAX_WIDTH];
    fire_t             right_in [MAX_WIDTH];
    row_t              cur_row;
    row_t              next_row;
    row_t              adv_row;

    // access op
    logic       in_area;
    logic [1:0] old_cell;
    logic       acc_write;
    row_t       acc_row;

    // -------------------------------------------------------------- sizes
    assign w_act = (board_width_reg < MIN_SIZE) ? MIN_SIZE :
                   (board_width_reg > MAX_W_SZ) ? MAX_W_SZ : board_width_reg;
    assign h_act = (board_height_reg < MIN_SIZE) ? MIN_SIZE :
                   (board_height_reg > MAX_H_SZ) ? MAX_H_SZ : board_height_reg;
    assign w_m1_full = w_act - SIZE_W'(1);
    assign h_m1_full = h_act - SIZE_W'(1);
    assign w_m1 = w_m1_full[COL_W-1:0];
    assign h_m1 = h_m1_full[ROW_W-1:0];

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            board_width_reg  <= MAX_W_SZ;
            board_height_reg <= MAX_H_SZ;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                CFG_WIDTH:  board_width_reg  <= cfg.data;
                CFG_HEIGHT: board_height_reg <= cfg.data;
                default:    ;
            endcase
        end
    end

    // -------------------------------------------------------------- memory
    // rows read in order h-1, 0, 1, ..., h-1 during an advance
    assign adv_issue = (state_reg == ST_ADV) && (rd_cnt_reg <= h_act);
    assign rd_cnt_m1 = rd_cnt_reg - SIZE_W'(1);

    always_comb
    begin
        if (state_reg == ST_ADV)
        begin
            mem_raddr = (rd_cnt_reg == '0) ? h_m1 : rd_cnt_m1[ROW_W-1:0];
        end
        else
        begin
            mem_raddr = items.row;
        end
    end

    assign mem_we    = wr_pend_reg || ((state_reg == ST_ACC) && acc_write);
    assign mem_waddr = wr_pend_reg ? wr_row_reg : op_row_reg;
    assign mem_wdata = wr_pend_reg ? adv_row : acc_row;

    brb_grid_mem u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (rd_row)
    );

    // -------------------------------------------------------------- cell chain
    // final shift brings in the saved old row 0 as the wrap below row h-1
    assign shift_en   = arr_valid_reg || fin_reg;
    assign shift_data = fin_reg ? row0_reg : rd_row;

    for (genvar c = 0; c < MAX_WIDTH; c++)
    begin : g_col
        if (c == 0)
        begin : g_left_wrap
            assign left_in[c] = fire[w_m1];
        end
        else
        begin : g_left
            assign left_in[c] = fire[c-1];
        end

        if (c == MAX_WIDTH - 1)
        begin : g_right_wrap
            assign right_in[c] = fire[0];
        end
        else
        begin : g_right
            assign right_in[c] = (w_m1 == COL_W'(c)) ? fire[0] : fire[c+1];
        end

        brb_cell u_cell (
            .clk        (clk),
            .shift_en   (shift_en),
            .load_state (shift_data[c]),
            .left       (left_in[c]),
            .right      (right_in[c]),
            .fire       (fire[c]),
            .cur_state  (cur_row[c]),
            .next_state (next_row[c])
        );

        // columns outside the active width keep their contents
        assign adv_row[c] = (COL_W'(c) <= w_m1) ? next_row[c] : cur_row[c];
    end

    // -------------------------------------------------------------- cell access
    assign in_area  = ({1'b0, op_row_reg} < h_act) && ({1'b0, op_col_reg} < w_act);
    assign old_cell = rd_row[op_col_reg];
    assign acc_write = (op_mode_reg == MODE_WRITE) && in_area && (op_wv_reg != CELL_BAD);

    always_comb
    begin
        acc_row             = rd_row;
        acc_row[op_col_reg] = op_wv_reg;
    end

    // -------------------------------------------------------------- payload registers
    assign arr_cnt_m2 = arr_cnt_reg - SIZE_W'(2);

    always_ff @(posedge clk)
    begin
        if (items.valid && items.ready)
        begin
            op_mode_reg <= items.mode;
            op_row_reg  <= items.row;
            op_col_reg  <= items.column;
            op_wv_reg   <= items.write_value;
        end
        if (arr_valid_reg && (arr_cnt_reg == SIZE_W'(1)))
        begin
            row0_reg <= rd_row;
        end
        wr_row_reg <= fin_reg ? h_m1 : arr_cnt_m2[ROW_W-1:0];
    end

    // -------------------------------------------------------------- control
    assign items.ready        = (state_reg == ST_IDLE);
    assign results.valid      = out_valid_reg;
    assign results.read_value = out_value_reg;

    // result register takes a new value when empty or emptied in this cycle
    assign out_load = (state_reg == ST_FIN) && (!out_valid_reg || results.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_cnt_reg    <= '0;
            arr_valid_reg <= 1'b0;
            arr_cnt_reg   <= '0;
            fin_reg       <= 1'b0;
            wr_pend_reg   <= 1'b0;
            wr_last_reg   <= 1'b0;
            res_reg       <= CELL_OFF;
            out_valid_reg <= 1'b0;
            out_value_reg <= CELL_OFF;
        end
        else
        begin
            // advance pipeline: read issue -> window shift -> row write-back
            arr_valid_reg <= adv_issue;
            arr_cnt_reg   <= rd_cnt_reg;
            fin_reg       <= arr_valid_reg && (arr_cnt_reg == h_act);
            wr_pend_reg   <= (arr_valid_reg && (arr_cnt_reg >= SIZE_W'(2))) || fin_reg;
            wr_last_reg   <= fin_reg;
            if (adv_issue)
            begin
                rd_cnt_reg <= rd_cnt_reg + SIZE_W'(1);
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                out_value_reg <= res_reg;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (items.valid)
                    begin
                        rd_cnt_reg <= '0;
                        res_reg    <= CELL_OFF;
                        unique case (items.mode)
                            MODE_WRITE, MODE_READ: state_reg <= ST_ACC;
                            MODE_ADVANCE:          state_reg <= ST_ADV;
                            default:               state_reg <= ST_FIN;
                        endcase
                    end
                end
                ST_ACC:
                begin
                    if (!in_area)
                    begin
                        res_reg <= CELL_OFF;
                    end
                    else if (acc_write)
                    begin
                        res_reg <= op_wv_reg;
                    end
                    else
                    begin
                        res_reg <= old_cell;
                    end
                    state_reg <= ST_FIN;
                end
                ST_ADV:
                begin
                    if (wr_pend_reg && wr_last_reg)
                    begin
                        res_reg   <= CELL_OFF;
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    if (out_load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // -------------------------------------------------------------- checks
    // no new item is taken while one is in flight
    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !items.ready)
        else $error("item accepted while busy");

    // advance write-back stays inside the active rows
    a_adv_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_pend_reg |-> ({1'b0, wr_row_reg} < h_act))
        else $error("advance wrote a row outside the board");

    // an access only writes memory for a write op
    a_acc_write_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && !wr_pend_reg) |-> (op_mode_reg == MODE_WRITE))
        else $error("memory write from a read access");

    // advance and no-op give zero
    a_adv_zero: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_FIN) && (op_mode_reg == MODE_ADVANCE || op_mode_reg == MODE_NOP))
        |-> (res_reg == CELL_OFF))
        else $error("advance result not zero");

    // write-back pipeline only runs during an advance
    a_wb_in_adv: assert property (@(posedge clk) disable iff (!rst_n)
        wr_pend_reg |-> (state_reg == ST_ADV))
        else $error("row write-back outside advance");

endmodule

`default_nettype wire

// ----- sim/brians_brain_generation_step_tb.sv -----
// Testbench for the Brian's Brain generation step block: random and directed cell ops.
`timescale 1ns / 100ps

module brians_brain_generation_step_tb;
    import brb_pkg::*;

    // Margin that covers the longest advance, at h = 64, after the
    // last result has come back, before any size register is touched.
    localparam int DRAIN_CYCLES = 80;
    // Length of the long result-side hold-off used to back the block up.
    localparam int HOLD_CYCLES  = 300;

    // One outstanding cell op and the read_value it must produce.
    typedef struct {
        logic [1:0]       op;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] column;
        logic [1:0]       value;
    } cell_expect_t;

    logic clk = 1'b0;
    logic rst_n;

    brb_item_if   item_bus ();
    brb_result_if result_bus ();
    brb_cfg_if    cfg_bus ();

    brians_brain_generation_step i_dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (item_bus),
        .results (result_bus),
        .cfg     (cfg_bus)
    );

    // Shadow of the grid and the size registers, updated at each accepted transfer.
    logic [1:0]        board_cells [MAX_HEIGHT][MAX_WIDTH];
    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;

    cell_expect_t pending_reads [$];
    int           mismatch_count = 0;

    // Random idling on both sides; cleared for the stretch with no gaps at all.
    bit          idle_on    = 1'b1;
    // Pulsed by a test to start one long hold-off of the result side.
    bit          hold_start = 1'b0;
    int unsigned hold_left  = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    //--------------------------------------------------------------------------
    // Predictor
    //--------------------------------------------------------------------------

    // Size registers are clamped to 3..limit before use.
    function automatic int unsigned active_size(logic [SIZE_W-1:0] raw, int unsigned limit);
        if (raw < 3)
            return 3;
        if (raw > limit)
            return limit;
        return raw;
    endfunction

    function automatic int unsigned firing_at(int unsigned r, int unsigned c);
        return (board_cells[r][c] == CELL_FIRING) ? 1 : 0;
    endfunction

    // One generation over the active area, with rows and columns wrapping at the
    // active size. Cells outside the active area keep their state.
    function automatic void step_generation();
        int unsigned w;
        int unsigned h;
        int unsigned up;
        int unsigned dn;
        int unsigned lf;
        int unsigned rt;
        int unsigned n;
        logic [1:0]  next_cells [MAX_HEIGHT][MAX_WIDTH];
        w = active_size(width_reg, MAX_WIDTH);
        h = active_size(height_reg, MAX_HEIGHT);
        next_cells = board_cells;
        for (int r = 0; r < h; r++)
        begin
            up = (r + h - 1) % h;
            dn = (r + 1) % h;
            for (int c = 0; c < w; c++)
            begin
                lf = (c + w - 1) % w;
                rt = (c + 1) % w;
                n = firing_at(up, lf) + firing_at(up, c) + firing_at(up, rt)
                  + firing_at(r, lf) + firing_at(r, rt)
                  + firing_at(dn, lf) + firing_at(dn, c) + firing_at(dn, rt);
                case (board_cells[r][c])
                    CELL_FIRING: next_cells[r][c] = CELL_DYING;
                    CELL_DYING:  next_cells[r][c] = CELL_OFF;
                    default:     next_cells[r][c] = (n == 2) ? CELL_FIRING : CELL_OFF;
                endcase
            end
        end
        board_cells = next_cells;
    endfunction

    // Applies one cell op to the shadow grid and returns the read_value it gives.
    function automatic logic [1:0] predict_cell_op(logic [1:0] op, logic [ROW_W-1:0] r,
                                                   logic [COL_W-1:0] c, logic [1:0] wv);
        int unsigned w;
        int unsigned h;
        bit          in_area;
        logic [1:0]  value;
        w = active_size(width_reg, MAX_WIDTH);
        h = active_size(height_reg, MAX_HEIGHT);
        in_area = (r < h) && (c < w);
        value = CELL_OFF;
        case (op)
            MODE_WRITE:
            begin
                // outside the board: ignored; value 3: cell keeps its state
                if (in_area)
                begin
                    if (wv != CELL_BAD)
                        board_cells[r][c] = wv;
                    value = board_cells[r][c];
                end
            end
            MODE_READ:
            begin
                if (in_area)
                    value = board_cells[r][c];
            end
            MODE_ADVANCE: step_generation();
            default: ;
        endcase
        return value;
    endfunction

    //--------------------------------------------------------------------------
    // Result side: ready pattern and checking
    //--------------------------------------------------------------------------

    // Ready is low for the whole hold-off, otherwise low at random about 37 percent
    // of the time while idling is on.
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            result_bus.ready <= 1'b0;
        end
        else if (hold_start)
        begin
            hold_left <= HOLD_CYCLES;
            result_bus.ready <= 1'b0;
        end
        else
            result_bus.ready <= !(idle_on && ($urandom_range(99) < 37));
    end

    // Every result transfer is matched against the oldest outstanding op.
    always @(posedge clk)
    begin
        cell_expect_t exp_op;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            if (pending_reads.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: result with no op outstanding: expected none, actual %0d",
                         $time, result_bus.read_value);
            end
            else
            begin
                exp_op = pending_reads.pop_front();
                if (result_bus.read_value !== exp_op.value)
                begin
                    mismatch_count++;
                    $display({"%0t: read_value mismatch (mode %0d row %0d column %0d): ",
                              "expected %0d, actual %0d"}, $time, exp_op.op, exp_op.row,
                             exp_op.column, exp_op.value, result_bus.read_value);
                end
            end
        end
    end

    //--------------------------------------------------------------------------
    // Item side
    //--------------------------------------------------------------------------

    // Offers one cell op and waits for its transfer. Valid is left high so that
    // back-to-back ops go out without a bubble; callers lower it when done.
    task automatic send_cell_op(input logic [1:0] op, input logic [ROW_W-1:0] r,
                                input logic [COL_W-1:0] c, input logic [1:0] wv);
        while (idle_on && ($urandom_range(99) < 37))
        begin
            item_bus.valid <= 1'b0;
            @(posedge clk);
        end
        item_bus.valid       <= 1'b1;
        item_bus.mode        <= op;
        item_bus.row         <= r;
        item_bus.column      <= c;
        item_bus.write_value <= wv;
        do
            @(posedge clk);
        while (!item_bus.ready);
        pending_reads.push_back('{op, r, c, predict_cell_op(op, r, c, wv)});
    endtask

    // Random op: mostly inside the active board, firing-heavy writes so that
    // generations stay busy, with some advances, out-of-area addresses and no-ops.
    task automatic send_random_op();
        int unsigned w;
        int unsigned h;
        int unsigned pick;
        logic [1:0]       op;
        logic [ROW_W-1:0] r;
        logic [COL_W-1:0] c;
        logic [1:0]       wv;
        w = active_size(width_reg, MAX_WIDTH);
        h = active_size(height_reg, MAX_HEIGHT);
        pick = $urandom_range(99);
        if (pick < 48)
            op = MODE_WRITE;
        else if (pick < 78)
            op = MODE_READ;
        else if (pick < 95)
            op = MODE_ADVANCE;
        else
            op = MODE_NOP;
        if ($urandom_range(99) < 85)
        begin
            r = ROW_W'($urandom_range(h - 1));
            c = COL_W'($urandom_range(w - 1));
        end
        else
        begin
            r = ROW_W'($urandom_range(MAX_HEIGHT - 1));
            c = COL_W'($urandom_range(MAX_WIDTH - 1));
        end
        pick = $urandom_range(99);
        if (pick < 50)
            wv = CELL_FIRING;
        else if (pick < 70)
            wv = CELL_OFF;
        else if (pick < 90)
            wv = CELL_DYING;
        else
            wv = CELL_BAD;
        send_cell_op(op, r, c, wv);
    endtask

    // Stops offering ops, waits for every outstanding result, then lets the
    // block settle so that the size registers may be written.
    task automatic wait_drained();
        item_bus.valid <= 1'b0;
        while (pending_reads.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Writes both size registers, back to back on the config channel.
    task automatic configure_board(input logic [SIZE_W-1:0] w_raw,
                                   input logic [SIZE_W-1:0] h_raw);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= CFG_WIDTH;
        cfg_bus.data  <= w_raw;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        width_reg = w_raw;
        cfg_bus.index <= CFG_HEIGHT;
        cfg_bus.data  <= h_raw;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        height_reg = h_raw;
        cfg_bus.valid <= 1'b0;
    endtask

    // Board size for a random phase: out-of-range values on either side, both
    // limits, and mostly small boards so that advances stay short.
    function automatic logic [SIZE_W-1:0] random_size_reg();
        case ($urandom_range(9))
            0:       return SIZE_W'($urandom_range(2));
            1:       return SIZE_W'($urandom_range(127, 65));
            2:       return MAX_W_SZ;
            3:       return MIN_SIZE;
            4:       return SIZE_W'($urandom_range(64, 13));
            default: return SIZE_W'($urandom_range(12, 3));
        endcase
    endfunction

    //--------------------------------------------------------------------------
    // Tests
    //--------------------------------------------------------------------------

    task automatic apply_reset();
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
    endtask

    // Full 64 x 64 board: corners after reset, extreme values, the ignored
    // value-3 write, a no-op, and a birth that needs both wraps.
    task automatic test_cell_access();
        send_cell_op(MODE_READ, 0, 0, CELL_OFF);
        send_cell_op(MODE_READ, 63, 63, CELL_BAD);
        send_cell_op(MODE_WRITE, 0, 0, CELL_FIRING);
        send_cell_op(MODE_WRITE, 63, 63, CELL_DYING);
        send_cell_op(MODE_WRITE, 0, 0, CELL_BAD);
        send_cell_op(MODE_READ, 0, 0, CELL_OFF);
        send_cell_op(MODE_WRITE, 0, 63, CELL_FIRING);
        send_cell_op(MODE_NOP, 42, 21, CELL_DYING);
        // (63,0) sees (0,63) and (0,0) across both edges: exactly two, so it fires
        send_cell_op(MODE_ADVANCE, 63, 63, CELL_BAD);
        send_cell_op(MODE_READ, 0, 0, CELL_OFF);
        send_cell_op(MODE_READ, 63, 63, CELL_OFF);
        send_cell_op(MODE_READ, 63, 0, CELL_OFF);
        send_cell_op(MODE_ADVANCE, 0, 0, CELL_OFF);
        send_cell_op(MODE_READ, 0, 0, CELL_OFF);
        wait_drained();
    endtask

    // Size registers below and above range, ops outside the active area, and
    // cells outside the area surviving until the board grows again.
    task automatic test_size_clamp();
        configure_board(SIZE_W'(0), SIZE_W'(127));
        send_cell_op(MODE_WRITE, 0, 5, CELL_FIRING);
        send_cell_op(MODE_READ, 0, 63, CELL_OFF);
        send_cell_op(MODE_WRITE, 10, 1, CELL_FIRING);
        send_cell_op(MODE_WRITE, 10, 2, CELL_FIRING);
        send_cell_op(MODE_ADVANCE, 0, 0, CELL_OFF);
        send_cell_op(MODE_READ, 11, 0, CELL_OFF);
        wait_drained();
        configure_board(SIZE_W'(127), SIZE_W'(1));
        send_cell_op(MODE_READ, 3, 0, CELL_OFF);
        send_cell_op(MODE_READ, 0, 63, CELL_OFF);
        wait_drained();
        configure_board(MAX_W_SZ, MAX_H_SZ);
        send_cell_op(MODE_READ, 11, 0, CELL_OFF);
        wait_drained();
    endtask

    // Phases of random ops, each on a freshly sized board.
    task automatic test_random_phases(input int phase_count, input int ops_per_phase);
        for (int p = 0; p < phase_count; p++)
        begin
            configure_board(random_size_reg(), random_size_reg());
            for (int i = 0; i < ops_per_phase; i++)
                send_random_op();
            wait_drained();
        end
    endtask

    // Long stretch at full rate on both sides.
    task automatic test_full_rate();
        idle_on <= 1'b0;
        configure_board(SIZE_W'($urandom_range(10, 3)), SIZE_W'($urandom_range(10, 3)));
        for (int i = 0; i < 200; i++)
            send_random_op();
        wait_drained();
        idle_on <= 1'b1;
    endtask

    // Result side held off for a long time while ops keep coming, so the block
    // backs up and stalls its input.
    task automatic test_result_hold();
        configure_board(SIZE_W'($urandom_range(8, 3)), SIZE_W'($urandom_range(8, 3)));
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
        for (int i = 0; i < 50; i++)
            send_random_op();
        wait_drained();
    endtask

    initial
    begin
        item_bus.valid       = 1'b0;
        item_bus.mode        = MODE_NOP;
        item_bus.row         = '0;
        item_bus.column      = '0;
        item_bus.write_value = CELL_OFF;
        result_bus.ready     = 1'b0;
        cfg_bus.valid        = 1'b0;
        cfg_bus.index        = CFG_WIDTH;
        cfg_bus.data         = '0;
        foreach (board_cells[r, c])
            board_cells[r][c] = CELL_OFF;
        width_reg  = MAX_W_SZ;
        height_reg = MAX_H_SZ;

        apply_reset();
        test_cell_access();
        test_size_clamp();
        test_result_hold();
        test_random_phases(6, 100);
        test_full_rate();
        test_random_phases(6, 100);

        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Run limit, far beyond the slowest correct run.
    initial
    begin
        #4_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
